// ----- hw/rtl/ogru_pkg.sv -----
// ogru_pkg: shared types and constants of the occupancy grid ray update block
// item and result structs, state encoding, register indexes and reset values
// no dependencies
package ogru_pkg;

    typedef enum logic [0:0] {
        OP_TRACE = 1'b0,
        OP_READ  = 1'b1
    } t_op;

    typedef struct packed {
        t_op                operation;
        logic signed [11:0] start_x;
        logic signed [11:0] start_y;
        logic signed [11:0] end_x;
        logic signed [11:0] end_y;
    } t_in_item;

    typedef struct packed {
        logic signed [7:0] cell_value;
        logic [12:0]       cells_updated;
        logic [12:0]       cells_outside;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_RDOUT,
        ST_HIT,
        ST_WALK,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic valid;
        logic hit;
    } t_upd_ctl;

    localparam logic [1:0] REG_HIT_STEP  = 2'd0;
    localparam logic [1:0] REG_MISS_STEP = 2'd1;
    localparam logic [1:0] REG_MAX_ODDS  = 2'd2;
    localparam logic [1:0] REG_MIN_ODDS  = 2'd3;

    localparam logic [6:0]        HIT_STEP_RST  = 7'd10;
    localparam logic [6:0]        MISS_STEP_RST = 7'd3;
    localparam logic [6:0]        MAX_ODDS_RST  = 7'd125;
    localparam logic signed [7:0] MIN_ODDS_RST  = -8'sd127;

    localparam int ERR_W = 15;

endpackage

// ----- hw/rtl/ogru_grid_mem.sv -----
// ogru_grid_mem: single-port-write, single-port-read grid memory
// registered read, no reset of contents
// no package dependencies
module ogru_grid_mem #(
    parameter int DEPTH  = 65536,
    parameter int ADDR_W = 16
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [7:0]        i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [7:0]        o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/ogru_cell_upd.sv -----
// ogru_cell_upd: modify and write-back stage of the grid read-modify-write
// saturating hit/miss update with forwarding of a same-cycle write
// depends on ogru_pkg
module ogru_cell_upd #(
    parameter int ADDR_W = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  ogru_pkg::t_upd_ctl       i_issue,
    input  logic [ADDR_W-1:0]        i_issue_addr,
    input  logic [7:0]               i_rdata,
    input  logic [6:0]               i_hit_step,
    input  logic [6:0]               i_miss_step,
    input  logic [6:0]               i_max_odds,
    input  logic signed [7:0]        i_min_odds,
    output logic                     o_we,
    output logic [ADDR_W-1:0]        o_waddr,
    output logic [7:0]               o_wdata
);
    import ogru_pkg::*;

    t_upd_ctl          r_ctl;
    logic [ADDR_W-1:0] r_addr;
    logic              r_fwd;
    logic [7:0]        r_fwd_data;

    logic signed [7:0] old_v;
    logic signed [9:0] sum_v;
    logic signed [9:0] diff_v;
    logic [7:0]        new_v;

    always_comb begin
        old_v  = r_fwd ? r_fwd_data : i_rdata;
        sum_v  = {{2{old_v[7]}}, old_v} + $signed({3'b000, i_hit_step});
        diff_v = {{2{old_v[7]}}, old_v} - $signed({3'b000, i_miss_step});
        if (r_ctl.hit) begin
            if (sum_v >= $signed({3'b000, i_max_odds})) begin
                new_v = {1'b0, i_max_odds};
            end else begin
                new_v = sum_v[7:0];
            end
        end else begin
            if (diff_v <= $signed({{2{i_min_odds[7]}}, i_min_odds})) begin
                new_v = i_min_odds;
            end else begin
                new_v = diff_v[7:0];
            end
        end
    end

    assign o_we    = r_ctl.valid;
    assign o_waddr = r_addr;
    assign o_wdata = new_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
            r_fwd <= 1'b0;
        end else begin
            r_ctl <= i_issue;
            r_fwd <= r_ctl.valid && (i_issue_addr == r_addr);
        end
    end

    // payload of the write stage
    always_ff @(posedge i_clk) begin
        r_addr     <= i_issue_addr;
        r_fwd_data <= new_v;
    end

endmodule

// ----- hw/rtl/occupancy_grid_ray_update.sv -----
// occupancy_grid_ray_update: log-odds occupancy grid with Bresenham ray update
// top level: control sequencer, ray walker, config registers
// depends on ogru_pkg, ogru_grid_mem, ogru_cell_upd
//
//  channel   signals                             transfer when
//  -------   ---------------------------------   ---------------------
//  item in   start, busy, i_item                 start && !busy
//  result    o_strobe, o_result                  o_strobe (one cycle)
//  config    i_cfg_we, i_cfg_idx, i_cfg_wdata    i_cfg_we
//
// after reset the grid is cleared one cell a cycle, GRID_WIDTH*GRID_HEIGHT
// cells (65536 by default), with busy high; config writes are taken throughout
// a read gives its result in ST_RDOUT after ST_READ; a trace gives its result in ST_DRAIN
// after ST_HIT (end cell) and ST_WALK, which visits the N = max(|dx|,|dy|)+1 ray cells,
// one cell per cycle through the single read port of the grid memory
// busy stays high through the result cycle; the receiver cannot stall
module occupancy_grid_ray_update #(
    parameter int GRID_WIDTH  = 256,
    parameter int GRID_HEIGHT = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  ogru_pkg::t_in_item  i_item,
    output logic                o_strobe,
    output ogru_pkg::t_out_item o_result,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [7:0]          i_cfg_wdata
);
    import ogru_pkg::*;

    localparam int DEPTH  = GRID_WIDTH * GRID_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic signed [12:0] GW_S = 13'(GRID_WIDTH);
    localparam logic signed [12:0] GH_S = 13'(GRID_HEIGHT);

    t_state r_state;
    t_state n_state;

    logic [6:0]        r_hit_step;
    logic [6:0]        r_miss_step;
    logic [6:0]        r_max_odds;
    logic signed [7:0] r_min_odds;

    logic [ADDR_W-1:0] r_clr_addr;

    logic signed [11:0]      r_x;
    logic signed [11:0]      r_y;
    logic signed [11:0]      r_ex;
    logic signed [11:0]      r_ey;
    logic [11:0]             r_dx;
    logic [11:0]             r_dy;
    logic signed [ERR_W-1:0] r_err;
    logic                    r_stx;
    logic                    r_sty;
    logic [12:0]             r_upd;
    logic [12:0]             r_outs;

    logic                    accept;
    logic                    clr_done;
    logic                    at_end;
    logic                    sel_end;
    logic signed [11:0]      ax;
    logic signed [11:0]      ay;
    logic                    a_inside;
    logic [ADDR_W-1:0]       a_addr;
    logic signed [12:0]      sdx;
    logic signed [12:0]      sdy;
    logic [11:0]             adx;
    logic [11:0]             ady;
    logic signed [ERR_W:0]   e2;
    logic                    step_x;
    logic                    step_y;
    logic signed [ERR_W-1:0] err_nx;

    t_upd_ctl          issue;
    logic              upd_we;
    logic [ADDR_W-1:0] upd_waddr;
    logic [7:0]        upd_wdata;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic [7:0]        mem_rdata;

    // cell address and bounds of the selected cell
    always_comb begin
        sel_end  = (r_state == ST_HIT);
        ax       = sel_end ? r_ex : r_x;
        ay       = sel_end ? r_ey : r_y;
        a_inside = !ax[11] && !ay[11] &&
                   ($signed({1'b0, ax}) < GW_S) && ($signed({1'b0, ay}) < GH_S);
        a_addr   = ADDR_W'(32'(ay[10:0]) * 32'(GRID_WIDTH) + 32'(ax[10:0]));
    end

    // ray setup from the incoming item
    always_comb begin
        sdx = {i_item.end_x[11], i_item.end_x} - {i_item.start_x[11], i_item.start_x};
        sdy = {i_item.end_y[11], i_item.end_y} - {i_item.start_y[11], i_item.start_y};
        adx = sdx[12] ? 12'(-sdx) : sdx[11:0];
        ady = sdy[12] ? 12'(-sdy) : sdy[11:0];
    end

    // bresenham step
    always_comb begin
        e2     = {r_err, 1'b0};
        step_x = e2 >= -$signed({{(ERR_W-11){1'b0}}, r_dy});
        step_y = e2 <= $signed({{(ERR_W-11){1'b0}}, r_dx});
        err_nx = r_err
               - (step_x ? $signed({{(ERR_W-12){1'b0}}, r_dy}) : '0)
               + (step_y ? $signed({{(ERR_W-12){1'b0}}, r_dx}) : '0);
        at_end = (r_x == r_ex) && (r_y == r_ey);
    end

    assign accept   = start && (r_state == ST_IDLE);
    assign clr_done = (r_clr_addr == ADDR_W'(DEPTH - 1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: if (clr_done) n_state = ST_IDLE;
            ST_IDLE: begin
                if (start) begin
                    n_state = (i_item.operation == OP_READ) ? ST_READ : ST_HIT;
                end
            end
            ST_READ:  n_state = ST_RDOUT;
            ST_RDOUT: n_state = ST_IDLE;
            ST_HIT:   n_state = ST_WALK;
            ST_WALK:  if (at_end) n_state = ST_DRAIN;
            ST_DRAIN: n_state = ST_IDLE;
            default:  n_state = ST_CLEAR;
        endcase
    end

    // outputs
    always_comb begin
        busy     = (r_state != ST_IDLE);
        o_strobe = 1'b0;
        o_result = '0;
        issue    = '0;
        case (r_state)
            ST_HIT: begin
                issue.valid = a_inside;
                issue.hit   = 1'b1;
            end
            ST_WALK: begin
                issue.valid = a_inside;
            end
            ST_RDOUT: begin
                o_strobe            = 1'b1;
                o_result.cell_value = a_inside ? mem_rdata : '0;
            end
            ST_DRAIN: begin
                o_strobe               = 1'b1;
                o_result.cells_updated = r_upd;
                o_result.cells_outside = r_outs;
            end
            default: begin
                issue = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (r_state == ST_CLEAR) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_step  <= HIT_STEP_RST;
            r_miss_step <= MISS_STEP_RST;
            r_max_odds  <= MAX_ODDS_RST;
            r_min_odds  <= MIN_ODDS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_HIT_STEP:  r_hit_step  <= i_cfg_wdata[6:0];
                REG_MISS_STEP: r_miss_step <= i_cfg_wdata[6:0];
                REG_MAX_ODDS:  r_max_odds  <= i_cfg_wdata[6:0];
                REG_MIN_ODDS:  r_min_odds  <= i_cfg_wdata;
                default:       r_min_odds  <= r_min_odds;
            endcase
        end
    end

    // ray walker and counters
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x    <= i_item.start_x;
            r_y    <= i_item.start_y;
            r_ex   <= i_item.end_x;
            r_ey   <= i_item.end_y;
            r_dx   <= adx;
            r_dy   <= ady;
            r_err  <= $signed({{(ERR_W-12){1'b0}}, adx})
                    - $signed({{(ERR_W-12){1'b0}}, ady});
            r_stx  <= !sdx[12] && (sdx != '0);
            r_sty  <= !sdy[12] && (sdy != '0);
            r_upd  <= '0;
            r_outs <= '0;
        end else if (r_state == ST_HIT) begin
            if (!a_inside) begin
                r_outs <= r_outs + 1'b1;
            end
        end else if (r_state == ST_WALK) begin
            if (a_inside) begin
                r_upd <= r_upd + 1'b1;
            end else begin
                r_outs <= r_outs + 1'b1;
            end
            if (!at_end) begin
                r_err <= err_nx;
                if (step_x) r_x <= r_stx ? r_x + 12'sd1 : r_x - 12'sd1;
                if (step_y) r_y <= r_sty ? r_y + 12'sd1 : r_y - 12'sd1;
            end
        end
    end

    assign mem_we    = (r_state == ST_CLEAR) ? 1'b1 : upd_we;
    assign mem_waddr = (r_state == ST_CLEAR) ? r_clr_addr : upd_waddr;
    assign mem_wdata = (r_state == ST_CLEAR) ? 8'd0 : upd_wdata;

    ogru_grid_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (a_addr),
        .o_rdata (mem_rdata)
    );

    ogru_cell_upd #(
        .ADDR_W (ADDR_W)
    ) u_upd (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_issue      (issue),
        .i_issue_addr (a_addr),
        .i_rdata      (mem_rdata),
        .i_hit_step   (r_hit_step),
        .i_miss_step  (r_miss_step),
        .i_max_odds   (r_max_odds),
        .i_min_odds   (r_min_odds),
        .o_we         (upd_we),
        .o_waddr      (upd_waddr),
        .o_wdata      (upd_wdata)
    );

`ifndef SYNTH
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe longer than one cycle");

    a_no_upd_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !upd_we)
        else $error("cell write during clearing pass");

    a_issue_in_trace: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        issue.valid |-> (r_state == ST_HIT || r_state == ST_WALK))
        else $error("cell update issued outside a trace");

    a_drain_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |=> !upd_we)
        else $error("cell write pending after trace result");
`endif

endmodule
